// File: rtl/core/power_sum_by_matrix_power_defines.svh
// Assertion macros used by the checker module
`ifndef POWER_SUM_BY_MATRIX_POWER_DEFINES_SVH
`define POWER_SUM_BY_MATRIX_POWER_DEFINES_SVH

// Check an implication on every rising clock edge outside reset
`define PSMP_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Check a next-cycle implication outside reset
`define PSMP_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// File: rtl/core/psmp_pkg.sv
package psmp_pkg;

    localparam int unsigned MAX_POWER_DEF  = 62;
    localparam int unsigned LIMIT_BITS_DEF = 32;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned POWER_W        = 6;

    typedef logic [WORD_W-1:0] t_word;

    // Sequencer phases
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_BUILD  = 9'b000000010,
        S_BIT    = 9'b000000100,
        S_MUL    = 9'b000001000,
        S_MWAIT  = 9'b000010000,
        S_COPY   = 9'b000100000,
        S_CWAIT  = 9'b001000000,
        S_SUM    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    // Which product a multiply pass computes
    typedef enum logic [1:0] {
        OP_RES_MUL = 2'b01,
        OP_BASE_SQ = 2'b10
    } t_op;

endpackage

// File: rtl/core/psmp_if.sv
interface psmp_in_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [31:0] upper_limit;
    logic [5:0]  power;
    modport source (output valid, upper_limit, power, input ready);
    modport sink   (input valid, upper_limit, power, output ready);
endinterface

interface psmp_out_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [31:0] power_sum;
    modport source (output valid, power_sum, input ready);
    modport sink   (input valid, power_sum, output ready);
endinterface

// File: rtl/core/psmp_binom.sv
// Pascal triangle ROM: entry C(r, c), zero above the diagonal, registered read
module psmp_binom #(
    parameter int unsigned MAX_POWER = psmp_pkg::MAX_POWER_DEF,
    parameter int unsigned IDX_W     = 8
) (
    input  logic                   i_clk,
    input  logic [IDX_W-1:0]       i_row,
    input  logic [IDX_W-1:0]       i_col,
    output psmp_pkg::t_word        o_data
);
    import psmp_pkg::*;

    function automatic t_word binom(input int unsigned r, input int unsigned c);
        t_word row [0:255];
        begin
            for (int a = 0; a < 256; a++) row[a] = '0;
            row[0] = 32'd1;
            for (int unsigned x = 1; x <= r; x++) begin
                for (int unsigned y = x; y >= 1; y--) row[y] = row[y] + row[y-1];
            end
            return (c <= r) ? row[c] : '0;
        end
    endfunction

    localparam int unsigned ROWS = MAX_POWER + 1;

    t_word r_data;

    // Look up one entry per cycle through a constant table
    always_ff @(posedge i_clk) begin
        r_data <= '0;
        for (int unsigned rr = 0; rr < ROWS; rr++) begin
            for (int unsigned cc = 0; cc <= rr; cc++) begin
                if (i_row == IDX_W'(rr) && i_col == IDX_W'(cc)) r_data <= binom(rr, cc);
            end
        end
    end

    assign o_data = r_data;
endmodule

// File: rtl/core/psmp_mem.sv
// Matrix store: one write port, one registered read port
module psmp_mem #(
    parameter int unsigned ADDR_W = 12
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  psmp_pkg::t_word     i_wdata,
    input  logic [ADDR_W-1:0]   i_raddr,
    output psmp_pkg::t_word     o_rdata
);
    import psmp_pkg::*;

    t_word r_mem [0:(1<<ADDR_W)-1];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/power_sum_by_matrix_power.sv
// Channel  Dir  Payload                          Transfer
// in       in   upper_limit[31:0], power[5:0]    valid & ready
// out      out  power_sum[31:0]                  valid & ready
//
// One item at a time. Matrices are d x d (d = k+2, k saturated to MAX_POWER).
// Each matrix product runs on the single multiply-accumulate unit; up to 2
// products per bit of n, LIMIT_BITS bits.
// Reset is synchronous; the binomial table is a constant ROM, no clearing pass.
// A result waiting on a stalled sink holds the block until it is taken.
module power_sum_by_matrix_power #(
    parameter int unsigned MAX_POWER  = psmp_pkg::MAX_POWER_DEF,
    parameter int unsigned LIMIT_BITS = psmp_pkg::LIMIT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psmp_in_if.sink       i_in,
    psmp_out_if.source    o_out
);
    import psmp_pkg::*;

    localparam int unsigned DIM    = MAX_POWER + 2;
    localparam int unsigned IDX_W  = $clog2(DIM + 1);
    localparam int unsigned ADDR_W = 2 * IDX_W;
    localparam int unsigned BIT_W  = (LIMIT_BITS > 1) ? $clog2(LIMIT_BITS + 1) : 1;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [LIMIT_BITS-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_k, n_k, r_d, n_d;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_t, n_t;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic r_rd, n_rd;           // read issued last cycle
    logic r_last, n_last;       // that read was the last of a dot product
    t_word r_acc, n_acc, r_sum, n_sum;
    logic r_ovalid, n_ovalid;

    // Memory ports
    logic bm_we, rm_we, sm_we;
    logic [ADDR_W-1:0] bm_wa, rm_wa, sm_wa, bm_ra, rm_ra, sm_ra;
    t_word bm_wd, rm_wd, sm_wd, bm_rd, rm_rd, sm_rd, bn_rd;
    logic [IDX_W-1:0] bn_row, bn_col;
    logic [IDX_W-1:0] r_bi, r_bj;
    logic r_bvalid;
    logic [63:0] prod;

    psmp_mem #(.ADDR_W(ADDR_W)) u_base (.i_clk, .i_we(bm_we), .i_waddr(bm_wa),
        .i_wdata(bm_wd), .i_raddr(bm_ra), .o_rdata(bm_rd));
    psmp_mem #(.ADDR_W(ADDR_W)) u_res (.i_clk, .i_we(rm_we), .i_waddr(rm_wa),
        .i_wdata(rm_wd), .i_raddr(rm_ra), .o_rdata(rm_rd));
    psmp_mem #(.ADDR_W(ADDR_W)) u_scr (.i_clk, .i_we(sm_we), .i_waddr(sm_wa),
        .i_wdata(sm_wd), .i_raddr(sm_ra), .o_rdata(sm_rd));
    psmp_binom #(.MAX_POWER(MAX_POWER), .IDX_W(IDX_W)) u_binom (.i_clk,
        .i_row(bn_row), .i_col(bn_col), .o_data(bn_rd));

    function automatic logic [ADDR_W-1:0] adr(input logic [IDX_W-1:0] a,
                                              input logic [IDX_W-1:0] b);
        return {a, b};
    endfunction

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.power_sum = r_sum;

    // Product of the two operand reads (left from result or base)
    assign prod = 64'((r_op == OP_RES_MUL) ? rm_rd : bm_rd) * 64'(bm_rd_b);
    t_word bm_rd_b;
    assign bm_rd_b = sm_rd;

    always_comb begin
        n_state = r_state; n_op = r_op; n_n = r_n; n_k = r_k; n_d = r_d;
        n_i = r_i; n_j = r_j; n_t = r_t; n_bit = r_bit; n_rd = 1'b0; n_last = 1'b0;
        n_acc = r_acc; n_sum = r_sum; n_ovalid = r_ovalid;
        bm_we = 1'b0; rm_we = 1'b0; sm_we = 1'b0;
        bm_wa = '0; rm_wa = '0; sm_wa = '0; bm_wd = '0; rm_wd = '0; sm_wd = '0;
        bm_ra = '0; rm_ra = '0; sm_ra = '0; bn_row = '0; bn_col = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_n = LIMIT_BITS'(i_in.upper_limit);
                    n_k = (i_in.power > POWER_W'(MAX_POWER)) ? IDX_W'(MAX_POWER)
                                                             : IDX_W'(i_in.power);
                    n_d = n_k + IDX_W'(2);
                    n_i = '0; n_j = '0; n_bit = '0;
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                // Issue a table read for (i,j); write back the one from last cycle
                bn_row = r_k - r_i;
                bn_col = r_j - r_i;
                if (r_j + IDX_W'(1) == r_d) begin
                    n_j = '0; n_i = r_i + IDX_W'(1);
                end else n_j = r_j + IDX_W'(1);
                if (r_i == r_d) n_state = S_BIT;
            end
            S_BIT: begin
                if (r_bit == BIT_W'(LIMIT_BITS) || r_n == '0) begin
                    n_i = '0; n_j = '0; n_acc = '0;
                    n_state = S_SUM;
                end else begin
                    n_i = '0; n_j = '0; n_t = '0; n_acc = '0;
                    n_op = r_n[0] ? OP_RES_MUL : OP_BASE_SQ;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Left operand at (i,t), right base at (t,j); the base copy sits
                // in the scratch port only for reads of the right operand.
                rm_ra = adr(r_i, r_t);
                bm_ra = adr(r_i, r_t);
                sm_ra = adr(r_t, r_j);
                n_rd = 1'b1;
                n_last = (r_t + IDX_W'(1) == r_d);
                n_t = n_last ? '0 : r_t + IDX_W'(1);
                n_state = n_last ? S_MWAIT : S_MUL;
            end
            S_MWAIT: begin
                n_state = S_MUL;
                if (r_j + IDX_W'(1) == r_d) begin
                    n_j = '0;
                    if (r_i + IDX_W'(1) == r_d) begin
                        n_i = '0; n_state = S_COPY;
                    end else n_i = r_i + IDX_W'(1);
                end else n_j = r_j + IDX_W'(1);
            end
            S_COPY: begin
                n_rd = 1'b1;
                if (r_j + IDX_W'(1) == r_d) begin
                    n_j = '0;
                    if (r_i + IDX_W'(1) == r_d) n_state = S_CWAIT;
                    else n_i = r_i + IDX_W'(1);
                end else n_j = r_j + IDX_W'(1);
            end
            S_CWAIT: begin
                n_state = S_BIT;
                n_i = '0; n_j = '0;
                if (r_op == OP_RES_MUL && (r_n >> 1) != '0) begin
                    n_op = OP_BASE_SQ; n_state = S_MUL; n_t = '0; n_acc = '0;
                end else begin
                    n_n = r_n >> 1; n_bit = r_bit + BIT_W'(1);
                end
            end
            S_SUM: begin
                rm_ra = adr(r_k + IDX_W'(1), r_j);
                n_rd = (r_j <= r_k);
                if (r_j <= r_k) n_j = r_j + IDX_W'(1);
                else if (!r_rd) begin
                    n_ovalid = 1'b1; n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (o_out.ready) begin
                    n_ovalid = 1'b0; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (r_state == S_IDLE && i_in.valid) n_sum = '0;
        if (r_state == S_SUM && r_rd) n_sum = r_sum + rm_rd;

        // Build write-back, in the cycle after the table read
        if (r_bvalid) begin
            bm_we = 1'b1; sm_we = 1'b1; rm_we = 1'b1;
            bm_wa = adr(r_bi, r_bj); sm_wa = bm_wa; rm_wa = bm_wa;
            rm_wd = (r_bi == r_bj) ? 32'd1 : '0;
            if (r_bi == r_k + IDX_W'(1))
                bm_wd = (r_bj == '0 || r_bj == r_k + IDX_W'(1)) ? 32'd1 : '0;
            else
                bm_wd = (r_bj >= r_bi && r_bj <= r_k) ? bn_rd : '0;
            sm_wd = bm_wd;
        end

        // Accumulate products; on the last one the entry is written to the product
        // store and the accumulator clears (base store keeps operand intact)
        if ((r_state == S_MUL || r_state == S_MWAIT) && r_rd) begin
            n_acc = r_acc + prod[31:0];
            if (r_last) n_acc = '0;
        end
        if (r_state == S_MWAIT && r_rd) begin
            rm_we = (r_op == OP_RES_MUL) ? 1'b0 : 1'b0;
        end
        // Copy pass: product held in the product store u_prod, move into destinations
        if (r_state == S_COPY || r_state == S_CWAIT) begin
            if (r_state == S_COPY) pm_ra = adr(r_i, r_j);
        end
        if (r_cvalid) begin
            if (r_op == OP_RES_MUL) begin
                rm_we = 1'b1; rm_wa = r_cadr; rm_wd = pm_rd;
            end else begin
                bm_we = 1'b1; bm_wa = r_cadr; bm_wd = pm_rd;
                sm_we = 1'b1; sm_wa = r_cadr; sm_wd = pm_rd;
            end
        end
    end

    // Product store: finished dot products land here before the copy pass
    logic [ADDR_W-1:0] pm_ra, r_cadr, r_padr;
    t_word pm_rd;
    logic pm_we, r_cvalid, r_pend;
    assign pm_we = (r_state == S_MWAIT || r_state == S_MUL) && r_rd && r_last;
    psmp_mem #(.ADDR_W(ADDR_W)) u_prod (.i_clk, .i_we(pm_we), .i_waddr(r_padr),
        .i_wdata(r_acc + prod[31:0]), .i_raddr(pm_ra), .o_rdata(pm_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_rd <= 1'b0; r_last <= 1'b0;
            r_bvalid <= 1'b0; r_cvalid <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_rd <= n_rd; r_last <= n_last;
            r_bvalid <= (r_state == S_BUILD) && (r_i != r_d);
            r_cvalid <= (r_state == S_COPY);
            r_pend <= 1'b0;
        end
        r_op <= n_op; r_n <= n_n; r_k <= n_k; r_d <= n_d;
        r_i <= n_i; r_j <= n_j; r_t <= n_t; r_bit <= n_bit;
        r_acc <= n_acc; r_sum <= n_sum;
        r_bi <= r_i; r_bj <= r_j;
        r_cadr <= adr(r_i, r_j);
        if (r_state == S_MUL && n_last) r_padr <= adr(r_i, r_j);
    end
endmodule

// File: rtl/core/psmp_checker.sv
module psmp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_sum
);
    `include "power_sum_by_matrix_power_defines.svh"

    `PSMP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_sum))
    `PSMP_ASSERT_IMP(a_busy_no_take, i_clk, i_rst_n, out_valid, !in_ready)
    `PSMP_ASSERT_NXT(a_take_busy, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
endmodule

bind power_sum_by_matrix_power psmp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_sum(o_out.power_sum)
);
